### sv/mcbd_pkg.sv
// Shared types and constants for the mip chain box downsampler.
package mcbd_pkg;
  localparam int MaxLog2Size = 12;
  localparam int MaxChannels = 4;
  localparam int CfgLog2Size = 0;
  localparam int CfgChannels = 1;

  typedef struct packed {
    logic start;
    logic step;
    logic emit;
  } mcbd_cmd_t;

  typedef struct packed {
    logic done;
    logic is_last;
  } mcbd_sts_t;
endpackage

### sv/mcbd_ram.sv
// Generic single-port RAM with a registered read.
module mcbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### sv/mcbd_ctrl.sv
// Controller state machine that sequences the cascade for one item.
module mcbd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  logic                  out_fire,
  input  mcbd_pkg::mcbd_sts_t   sts,
  output mcbd_pkg::mcbd_cmd_t   cmd,
  output logic                  in_ready,
  output logic                  out_valid
);
  import mcbd_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StCalc = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      StIdle: begin
        if (in_fire) begin
          cmd.start = 1'b1;
          state_next = StOut;
        end
      end
      StRead: begin
        state_next = StCalc;
      end
      StCalc: begin
        cmd.step = 1'b1;
        state_next = StOut;
      end
      StOut: begin
        if (out_fire) begin
          cmd.emit = 1'b1;
          if (sts.done) begin
            state_next = StIdle;
          end else begin
            state_next = StRead;
          end
        end
      end
      default: state_next = StIdle;
    endcase
  end

  assign in_ready  = (state == StIdle);
  assign out_valid = (state == StOut);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_no_out_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("output valid while idle");
  a_start_goes_out: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid) else $error("start did not present a result");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_fire && sts.done) |=> in_ready) else $error("no return to idle");
`endif
endmodule

### sv/mcbd_dp.sv
// Datapath: position, per-level hold registers, pair store and averaging.
module mcbd_dp #(
  parameter int MaxLog2 = mcbd_pkg::MaxLog2Size,
  parameter int MaxCh   = mcbd_pkg::MaxChannels
) (
  input  logic                clk,
  input  logic                rst,
  input  mcbd_pkg::mcbd_cmd_t cmd,
  output mcbd_pkg::mcbd_sts_t sts,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [3:0]          cfg_data,
  input  logic [31:0]         pixel_in,
  output logic [3:0]          level,
  output logic [11:0]         col,
  output logic [11:0]         row,
  output logic [31:0]         pixel_out
);
  import mcbd_pkg::*;

  localparam int Depth = 1 << MaxLog2;
  localparam int AW = MaxLog2;
  localparam int PW = 9 * MaxCh;
  localparam int HW = (MaxLog2 > 1) ? $clog2(MaxLog2) : 1;

  logic [3:0]  log2_size;
  logic [2:0]  channels;
  logic [AW-1:0] pos_x, pos_y;
  logic [AW-1:0] cx, cy;
  logic [3:0]  lvl;
  logic [31:0] cur;
  logic [31:0] hold [MaxLog2];
  logic [3:0]  lg;
  logic [2:0]  nch;
  logic [AW:0] side;
  logic [AW-1:0] smask;
  logic [31:0] cmask;
  logic [AW-1:0] addr;
  logic        we;
  logic [PW-1:0] pr, rdata;
  logic [31:0] mean;
  logic        stop;
  logic [AW-1:0] sx_i, sy_i;

  assign lg  = (log2_size > 4'(MaxLog2)) ? 4'(MaxLog2) : log2_size;
  assign nch = (channels == 3'd0) ? 3'd1 :
               ((channels > 3'(MaxCh)) ? 3'(MaxCh) : channels);
  assign side  = (AW+1)'(1) << lg;
  assign smask = AW'(side - 1'b1);

  always_comb begin
    cmask = '0;
    for (int c = 0; c < 4; c++) begin
      if (c < int'(nch)) cmask[8*c +: 8] = 8'hFF;
    end
  end

  assign stop = (lvl >= lg) || !cx[0] || !cy[0];
  assign sts.done = stop;
  assign sts.is_last = stop;

  always_comb begin
    pr = '0;
    mean = '0;
    for (int c = 0; c < MaxCh; c++) begin
      if (c < int'(nch)) begin
        pr[9*c +: 9] = {1'b0, hold[lvl[HW-1:0]][8*c +: 8]}
                       + {1'b0, cur[8*c +: 8]};
        mean[8*c +: 8] = 8'(({2'b0, rdata[9*c +: 9]} + {2'b0, pr[9*c +: 9]} + 11'd2) >> 2);
      end
    end
  end

  assign addr = AW'((side - (side >> lvl)) + (AW+1)'(cx >> 1));
  assign we = cmd.emit && cx[0] && !cy[0] && (lvl < lg);

  mcbd_ram #(.Width(PW), .Depth(Depth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(pr), .rdata(rdata));

  assign sx_i = pos_x & smask;
  assign sy_i = pos_y & smask;

  always_ff @(posedge clk) begin
    if (rst) begin
      log2_size <= 4'd8;
      channels  <= 3'd4;
      pos_x <= '0;
      pos_y <= '0;
    end else if (cfg_we) begin
      if (cfg_index == 1'(CfgLog2Size)) log2_size <= cfg_data;
      else channels <= cfg_data[2:0];
      pos_x <= '0;
      pos_y <= '0;
    end else if (cmd.start) begin
      pos_x <= (pos_x + 1'b1) & smask;
      if (((pos_x + 1'b1) & smask) == '0) pos_y <= (pos_y + 1'b1) & smask;
      else pos_y <= pos_y & smask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur <= pixel_in & cmask;
      cx <= sx_i;
      cy <= sy_i;
      lvl <= '0;
    end else if (cmd.emit && !stop) begin
      cur <= cur;
    end else if (cmd.step) begin
      cur <= mean;
      lvl <= lvl + 1'b1;
      cx <= cx >> 1;
      cy <= cy >> 1;
    end
    if (cmd.emit && (lvl < lg) && !cx[0]) begin
      hold[lvl[HW-1:0]] <= cur;
    end
  end

  assign level = lvl;
  assign col = 12'(cx);
  assign row = 12'(cy);
  assign pixel_out = cur;
endmodule

### sv/mip_chain_box_downsampler.sv
// Top level of the mip chain box downsampler.
//  channel | direction | contents
//  s_axis  | in        | tdata: pixel_in[31:0]
//  m_axis  | out       | tdata: level, col, row, pixel_out; tlast: last
//  cfg     | in        | index 0 log2_size, 1 channels
// An item enters from s_axis, and its level 0 result is offered in the
// next cycle. Each further result of its cascade passes through the read and
// calc states, limited by the registered read of the pair store.
// Reset is synchronous; no new item enters until the last result is taken.
module mip_chain_box_downsampler #(
  parameter int MaxLog2 = mcbd_pkg::MaxLog2Size,
  parameter int MaxCh   = mcbd_pkg::MaxChannels
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // level, col, row, pixel_out
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import mcbd_pkg::*;

  mcbd_cmd_t cmd;
  mcbd_sts_t sts;
  logic [3:0]  level;
  logic [11:0] col, row;
  logic [31:0] pixel_out;

  mcbd_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_axis_tvalid && s_axis_tready),
    .out_fire(m_axis_tvalid && m_axis_tready),
    .sts(sts), .cmd(cmd), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid));

  mcbd_dp #(.MaxLog2(MaxLog2), .MaxCh(MaxCh)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pixel_in(s_axis_tdata), .level(level), .col(col), .row(row),
    .pixel_out(pixel_out));

  assign m_axis_tdata = {4'd0, pixel_out, row, col, level};
  assign m_axis_tlast = sts.is_last;
endmodule

### tb/mip_chain_box_downsampler_checker.sv
// Checker for the mip chain box downsampler: predicts the mip chain and compares the results.
module mip_chain_box_downsampler_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel_in
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // level, col, row, pixel_out
  input  logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output int          pending,
  output int          fail_count
);
  import mcbd_pkg::*;

  typedef struct {
    logic [3:0]  level;
    logic [11:0] col;
    logic [11:0] row;
    logic [31:0] pixel;
    logic        last;
  } mip_pixel_t;

  mip_pixel_t  mip_fifo[$];
  logic [3:0]  size_reg;
  logic [2:0]  chan_reg;
  int          pos_x;
  int          pos_y;
  logic [35:0] row_pairs[4096];
  logic [31:0] left_hold[MaxLog2Size];

  function automatic logic [35:0] pair_sum(logic [31:0] a, logic [31:0] b, int nch);
    logic [35:0] r;
    r = '0;
    for (int c = 0; c < nch; c++) begin
      r[9*c +: 9] = {1'b0, a[8*c +: 8]} + {1'b0, b[8*c +: 8]};
    end
    return r;
  endfunction

  function automatic logic [31:0] box_mean(logic [35:0] top, logic [35:0] bot, int nch);
    logic [31:0] r;
    logic [10:0] s;
    r = '0;
    for (int c = 0; c < nch; c++) begin
      s = {2'b0, top[9*c +: 9]} + {2'b0, bot[9*c +: 9]} + 11'd2;
      r[8*c +: 8] = s[9:2];
    end
    return r;
  endfunction

  task automatic push_mip(int lvl, int x, int y, logic [31:0] px);
    mip_pixel_t e;
    e.level = 4'(lvl);
    e.col   = 12'(x);
    e.row   = 12'(y);
    e.pixel = px;
    e.last  = 1'b0;
    mip_fifo.push_back(e);
  endtask

  task automatic predict_chain(logic [31:0] pixel_in);
    int lg, nch, side, cx, cy, lvl, idx;
    logic [31:0] mask, cur;
    logic [35:0] pr;
    lg   = (size_reg > MaxLog2Size) ? MaxLog2Size : int'(size_reg);
    nch  = (chan_reg == 0) ? 1 : ((chan_reg > MaxChannels) ? MaxChannels : int'(chan_reg));
    side = 1 << lg;
    mask = (nch == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nch)) - 32'd1);
    cur  = pixel_in & mask;
    cx   = pos_x & (side - 1);
    cy   = pos_y & (side - 1);
    lvl  = 0;
    push_mip(0, cx, cy, cur);
    while (lvl < lg) begin
      if ((cx & 1) == 0) begin
        left_hold[lvl] = cur;
        break;
      end
      idx = ((side - (side >> lvl)) + (cx >> 1)) & 4095;
      pr  = pair_sum(left_hold[lvl], cur, nch);
      if ((cy & 1) == 0) begin
        row_pairs[idx] = pr;
        break;
      end
      cur = box_mean(row_pairs[idx], pr, nch);
      lvl++;
      cx = cx >> 1;
      cy = cy >> 1;
      push_mip(lvl, cx, cy, cur);
    end
    mip_fifo[mip_fifo.size() - 1].last = 1'b1;
    pos_x = (pos_x + 1) & (side - 1);
    if (pos_x == 0) pos_y = (pos_y + 1) & (side - 1);
    else pos_y = pos_y & (side - 1);
  endtask

  task automatic check_mip(logic [63:0] d, logic tl);
    mip_pixel_t e;
    if (mip_fifo.size() == 0) begin
      $error("unexpected result item: tdata %h tlast %b", d, tl);
      fail_count++;
      return;
    end
    e = mip_fifo.pop_front();
    if (d[3:0] !== e.level) begin
      $error("level: expected %0d actual %0d", e.level, d[3:0]);
      fail_count++;
    end
    if (d[15:4] !== e.col) begin
      $error("col: expected %0d actual %0d", e.col, d[15:4]);
      fail_count++;
    end
    if (d[27:16] !== e.row) begin
      $error("row: expected %0d actual %0d", e.row, d[27:16]);
      fail_count++;
    end
    if (d[59:28] !== e.pixel) begin
      $error("pixel_out: expected %h actual %h", e.pixel, d[59:28]);
      fail_count++;
    end
    if (tl !== e.last) begin
      $error("last: expected %b actual %b", e.last, tl);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      size_reg = 4'd8;
      chan_reg = 3'd4;
      pos_x = 0;
      pos_y = 0;
      mip_fifo.delete();
      for (int i = 0; i < 4096; i++) row_pairs[i] = '0;
      for (int i = 0; i < MaxLog2Size; i++) left_hold[i] = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_mip(m_axis_tdata, m_axis_tlast);
      if (cfg_we) begin
        if (cfg_index == 1'(CfgLog2Size)) size_reg = cfg_data;
        else chan_reg = cfg_data[2:0];
        pos_x = 0;
        pos_y = 0;
      end
      if (s_axis_tvalid && s_axis_tready) predict_chain(s_axis_tdata);
    end
    pending = mip_fifo.size();
  end
endmodule

### tb/mip_chain_box_downsampler_tb.sv
// Testbench top for the mip chain box downsampler: stimulus, idling and verdict.
module mip_chain_box_downsampler_tb;
  import mcbd_pkg::*;

  localparam int StallLimit = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;
  logic        no_idle = 1'b0;
  logic        hold_req = 1'b0;
  int          pending;
  int          fail_count;
  int          quiet_cycles = 0;
  int          stall = 0;
  int          r;

  always #4 clk = ~clk;

  mip_chain_box_downsampler uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mip_chain_box_downsampler_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .fail_count(fail_count)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall <= 0;
    end else if (hold_req) begin
      m_axis_tready <= 1'b0;
      stall <= 300;
    end else if (stall > 0) begin
      m_axis_tready <= 1'b0;
      stall <= stall - 1;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m_axis_tready <= 1'b1;
      end else if (r < 95) begin
        m_axis_tready <= 1'b0;
        stall <= $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        stall <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [31:0] px);
    int gap;
    int pick;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    gap = 0;
    if (!no_idle) begin
      pick = $urandom_range(0, 9);
      if (pick >= 6) gap = (pick < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_pixel();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 32'h0;
    if (k == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= 1'(idx);
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_pixel(pick_pixel());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0);
    send_pixel(32'h8040_2010);
    settle();

    // A one-pixel image, with a channel count of zero taken as one.
    write_reg(CfgLog2Size, 4'd0);
    write_reg(CfgChannels, 4'd0);
    send_pixel(32'h0);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h1234_5678);
    settle();

    write_reg(CfgLog2Size, 4'd1);
    write_reg(CfgChannels, 4'hC);
    for (int i = 0; i < 4; i++) send_pixel(32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_pixel(32'h0);
    settle();

    // Oversized image and channel count clamp to the maximum.
    write_reg(CfgLog2Size, 4'd15);
    write_reg(CfgChannels, 4'd7);
    send_random(5);
    settle();

    // A write in the middle of a frame restarts it.
    write_reg(CfgLog2Size, 4'd2);
    write_reg(CfgChannels, 4'd2);
    send_random(5);
    settle();
    write_reg(CfgChannels, 4'd3);
    send_random(16);
    settle();

    write_reg(CfgLog2Size, 4'd3);
    write_reg(CfgChannels, 4'($urandom_range(1, 4)));
    no_idle <= 1'b1;
    send_random(32);
    no_idle <= 1'b0;
    send_random(32);
    settle();

    write_reg(CfgLog2Size, 4'd4);
    write_reg(CfgChannels, 4'($urandom_range(1, 4)));
    send_random(20);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    send_random(90);
    settle();

    write_reg(CfgLog2Size, 4'd12);
    write_reg(CfgChannels, 4'd1);
    send_random(40);
    settle();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### sim.f
sv/mcbd_pkg.sv
sv/mcbd_ram.sv
sv/mcbd_ctrl.sv
sv/mcbd_dp.sv
sv/mip_chain_box_downsampler.sv
tb/mip_chain_box_downsampler_checker.sv
tb/mip_chain_box_downsampler_tb.sv
